/* hw/rtl/pdi_pkg.sv */
// ----------------------------------------------------------------------------
// pdi_pkg
// Shared types, codes and helpers for the two-wire programming-interface
// frame engine.
// ----------------------------------------------------------------------------
package pdi_pkg;

    // operation codes of an input item
    localparam logic [2:0] OP_SEND_BYTE  = 3'd0;
    localparam logic [2:0] OP_SEND_IDLE  = 3'd1;
    localparam logic [2:0] OP_SEND_BREAK = 3'd2;
    localparam logic [2:0] OP_RECEIVE    = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;

    // receive status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_PARITY  = 2'd2;
    localparam logic [1:0] ST_BADSTOP = 2'd3;

    // frame layout
    localparam logic [3:0]  FRAME_BITS    = 4'd12;
    localparam logic [3:0]  RX_DATA_BITS  = 4'd8;
    localparam logic [3:0]  RX_PARITY_BIT = 4'd8;
    localparam logic [3:0]  RX_LAST_BIT   = 4'd10;
    localparam logic [11:0] FRAME_IDLE    = 12'hFFF;
    localparam logic [11:0] FRAME_BREAK   = 12'h000;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd250;

    // link phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TX     = 2'd1,
        PH_RXWAIT = 2'd2,
        PH_RXDATA = 2'd3
    } phase_t;

    // even parity over one byte
    function automatic logic parity8(input logic [7:0] b);
        return ^b;
    endfunction

    // data byte frame: start 0, data lsb first, parity, two stop 1s
    function automatic logic [11:0] byte_frame(input logic [7:0] b);
        return {2'b11, parity8(b), b, 1'b0};
    endfunction

endpackage

/* hw/rtl/pdi_frame_phy_core.sv */
// ----------------------------------------------------------------------------
// pdi_frame_phy_core
// Bit-level frame engine of a two-wire programming interface: sends byte,
// idle and break frames and receives a byte frame, one bit period per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries operation, data_byte and
//   line_in. A send or receive command arms the engine; each bit tick item
//   then drives or samples one bit period. Commands while busy are dropped
//   and flagged with rejected.
//   Output channel (out_valid / out_stall) returns exactly one result item
//   for every input item, in order.
//   cfg_wr_en / cfg_wr_data write rx_timeout; write only while idle.
// Pipeline and throughput:
//   An item sits in the input register, then its result is loaded into
//   the output register once that register is free of a stalled result.
//   One item per cycle is sustained while out_stall is low; the whole step
//   is one pass through the frame logic between the two registers.
// Reset:
//   Phase idle, line released, rx_timeout 250, both channels empty.
// Stall:
//   While out_stall holds a result, the input register keeps its item and
//   in_stall rises only once that register is occupied.
// ----------------------------------------------------------------------------
module pdi_frame_phy_core
    import pdi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  logic [7:0] data_byte,
    input  logic       line_in,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       line_out,
    output logic       line_drive,
    output logic       clock_run,
    output logic       busy_res,
    output logic       rx_done,
    output logic [7:0] rx_byte,
    output logic [1:0] rx_status,
    output logic       rejected
);

    // configuration register
    logic [7:0] rx_timeout_reg;

    // input register
    logic       in_vld_reg;
    logic [2:0] op_reg;
    logic [7:0] db_reg;
    logic       li_reg;

    // engine state
    phase_t      phase_reg, phase_next;
    logic [11:0] tx_frame_reg, tx_frame_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  wait_count_reg, wait_count_next;
    logic [7:0]  rx_shift_reg, rx_shift_next;
    logic [1:0]  rx_error_reg, rx_error_next;
    logic        drive_enable_reg, drive_enable_next;

    // result register
    logic       out_vld_reg;
    logic       lo_reg, ld_reg, clk_run_reg, busy_reg, done_reg, rej_reg;
    logic [7:0] rbyte_reg;
    logic [1:0] rstat_reg;
    logic       lo_next, ld_next, clk_run_next, done_next, rej_next;
    logic [7:0] rbyte_next;
    logic [1:0] rstat_next;

    // handshake
    logic advance;
    logic in_take;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // item decode
    logic is_cmd, is_tick, cmd_ok;
    logic tx_last, rx_last;

    assign is_cmd  = (op_reg == OP_SEND_BYTE) || (op_reg == OP_SEND_IDLE)
                  || (op_reg == OP_SEND_BREAK) || (op_reg == OP_RECEIVE);
    assign is_tick = (op_reg == OP_TICK);
    assign cmd_ok  = is_cmd && (phase_reg == PH_IDLE);
    assign tx_last = (bit_index_reg >= FRAME_BITS - 4'd1);
    assign rx_last = (bit_index_reg >= RX_LAST_BIT);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (cmd_ok)
        begin
            phase_next = (op_reg == OP_RECEIVE) ? PH_RXWAIT : PH_TX;
        end
        else if (is_tick)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_TX:
                begin
                    if (tx_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_RXWAIT:
                begin
                    priority if (wait_count_reg == 8'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (!li_reg)
                    begin
                        phase_next = PH_RXDATA;
                    end
                    else if (wait_count_reg == 8'd1)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_RXWAIT;
                    end
                end
                PH_RXDATA:
                begin
                    if (rx_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // datapath and result fields
    always_comb
    begin
        tx_frame_next     = tx_frame_reg;
        bit_index_next    = bit_index_reg;
        wait_count_next   = wait_count_reg;
        rx_shift_next     = rx_shift_reg;
        rx_error_next     = rx_error_reg;
        drive_enable_next = drive_enable_reg;
        ld_next           = drive_enable_reg;
        lo_next           = drive_enable_reg & tx_frame_reg[11];
        clk_run_next      = 1'b0;
        done_next         = 1'b0;
        rbyte_next        = 8'd0;
        rstat_next        = ST_OK;
        rej_next          = is_cmd && (phase_reg != PH_IDLE);

        if (cmd_ok)
        begin
            bit_index_next = 4'd0;
            priority if (op_reg == OP_RECEIVE)
            begin
                drive_enable_next = 1'b0;
                wait_count_next   = rx_timeout_reg;
                rx_shift_next     = 8'd0;
                rx_error_next     = ST_OK;
                ld_next           = 1'b0;
                lo_next           = 1'b0;
            end
            else if (op_reg == OP_SEND_BYTE)
            begin
                tx_frame_next = byte_frame(db_reg);
            end
            else if (op_reg == OP_SEND_IDLE)
            begin
                tx_frame_next = FRAME_IDLE;
            end
            else
            begin
                tx_frame_next = FRAME_BREAK;
            end
        end
        else if (is_tick)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    clk_run_next = 1'b0;
                end
                PH_TX:
                begin
                    drive_enable_next = 1'b1;
                    ld_next           = 1'b1;
                    lo_next           = (bit_index_reg < FRAME_BITS)
                                      ? tx_frame_reg[bit_index_reg] : 1'b1;
                    clk_run_next      = 1'b1;
                    bit_index_next    = bit_index_reg + 4'd1;
                end
                PH_RXWAIT:
                begin
                    ld_next = 1'b0;
                    lo_next = 1'b0;
                    if (wait_count_reg == 8'd0)
                    begin
                        done_next  = 1'b1;
                        rstat_next = ST_TIMEOUT;
                    end
                    else
                    begin
                        clk_run_next    = 1'b1;
                        wait_count_next = wait_count_reg - 8'd1;
                        priority if (!li_reg)
                        begin
                            bit_index_next = 4'd0;
                            rx_shift_next  = 8'd0;
                            rx_error_next  = ST_OK;
                        end
                        else if (wait_count_reg == 8'd1)
                        begin
                            done_next  = 1'b1;
                            rstat_next = ST_TIMEOUT;
                        end
                        else
                        begin
                            done_next = 1'b0;
                        end
                    end
                end
                PH_RXDATA:
                begin
                    ld_next      = 1'b0;
                    lo_next      = 1'b0;
                    clk_run_next = 1'b1;
                    // sample data, then parity, then stop bits
                    priority if (bit_index_reg < RX_DATA_BITS)
                    begin
                        rx_shift_next = rx_shift_reg
                                      | ({7'd0, li_reg} << bit_index_reg[2:0]);
                    end
                    else if (bit_index_reg == RX_PARITY_BIT)
                    begin
                        if (li_reg != parity8(rx_shift_reg))
                        begin
                            rx_error_next = ST_PARITY;
                        end
                    end
                    else
                    begin
                        if ((rx_error_reg == ST_OK) && !li_reg)
                        begin
                            rx_error_next = ST_BADSTOP;
                        end
                    end
                    if (rx_last)
                    begin
                        done_next      = 1'b1;
                        rbyte_next     = rx_shift_next;
                        rstat_next     = rx_error_next;
                        bit_index_next = 4'd0;
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + 4'd1;
                    end
                end
                default:
                begin
                    clk_run_next = 1'b0;
                end
            endcase
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            rx_timeout_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= operation;
            db_reg <= data_byte;
            li_reg <= line_in;
        end
    end

    // engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tx_frame_reg     <= FRAME_IDLE;
            bit_index_reg    <= 4'd0;
            wait_count_reg   <= 8'd0;
            rx_shift_reg     <= 8'd0;
            rx_error_reg     <= ST_OK;
            drive_enable_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            tx_frame_reg     <= tx_frame_next;
            bit_index_reg    <= bit_index_next;
            wait_count_reg   <= wait_count_next;
            rx_shift_reg     <= rx_shift_next;
            rx_error_reg     <= rx_error_next;
            drive_enable_reg <= drive_enable_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lo_reg      <= lo_next;
            ld_reg      <= ld_next;
            clk_run_reg <= clk_run_next;
            busy_reg    <= (phase_next != PH_IDLE);
            done_reg    <= done_next;
            rbyte_reg   <= rbyte_next;
            rstat_reg   <= rstat_next;
            rej_reg     <= rej_next;
        end
    end

    // output ports
    assign out_valid  = out_vld_reg;
    assign line_out   = lo_reg;
    assign line_drive = ld_reg;
    assign clock_run  = clk_run_reg;
    assign busy_res   = busy_reg;
    assign rx_done    = done_reg;
    assign rx_byte    = rbyte_reg;
    assign rx_status  = rstat_reg;
    assign rejected   = rej_reg;

    // a finished receive leaves the engine idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && done_reg) |-> !busy_reg)
        else $error("rx_done reported while still busy");

    // a dropped command never clocks a bit period
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && rej_reg) |-> !clk_run_reg)
        else $error("rejected command clocked the link");

    // the line stays released for the whole receive
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_RXWAIT) || (phase_reg == PH_RXDATA)) |-> !drive_enable_reg)
        else $error("line driven while receiving");

    // send index never runs past the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TX) |-> (bit_index_reg < FRAME_BITS))
        else $error("send bit index beyond frame");

    // input stall only backs up an occupied input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg))
        else $error("input stalled with room in the pipeline");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-wire frame engine. A short table of
// commands and bit ticks runs first, then random send and receive frames
// (with broken parity, bad stops, late or missing start bits and stray
// commands) under several rx_timeout settings. Every result item is checked
// field by field against a fixed table row or a cycle-free model of the engine.
// ----------------------------------------------------------------------------
module tb
    import pdi_pkg::*;
();

    // operation codes the engine ignores
    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;

    localparam int STUCK_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASE_COUNT  = 8;
    localparam int SETTLE_TICKS = 4;

    // one result item
    typedef struct packed {
        logic       line_out;
        logic       line_drive;
        logic       clock_run;
        logic       busy_res;
        logic       rx_done;
        logic [7:0] rx_byte;
        logic [1:0] rx_status;
        logic       rejected;
    } phy_res_t;

    // one row of the directed table
    typedef struct {
        logic [2:0] op;
        logic [7:0] db;
        logic       li;
        bit         fixed;
        phy_res_t   res;
    } dir_row_t;

    localparam phy_res_t R_QUIET   = '0;
    localparam phy_res_t R_ARMED   = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, ST_OK, 1'b0};
    localparam phy_res_t R_DROPPED = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, ST_OK, 1'b1};

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       line_in;
    logic       out_valid;
    logic       out_stall;
    logic       line_out;
    logic       line_drive;
    logic       clock_run;
    logic       busy_res;
    logic       rx_done;
    logic [7:0] rx_byte;
    logic [1:0] rx_status;
    logic       rejected;

    // model state of the engine
    phase_t      link_phase;
    logic [11:0] frame_bits;
    logic [3:0]  bit_pos;
    logic [7:0]  wait_left;
    logic [7:0]  rx_acc;
    logic [1:0]  rx_err;
    logic        drive_on;
    logic [7:0]  timeout_reg;

    phy_res_t pending_results [$];
    int       fail_count;
    int       items_sent;
    int       stuck_cycles;
    bit       calm;

    dir_row_t dir_tab [25] = '{
        '{OP_TICK,       8'h00, 1'b1, 1'b1, R_QUIET},
        '{OP_RSVD_A,     8'h5A, 1'b0, 1'b1, R_QUIET},
        '{OP_RSVD_C,     8'hFF, 1'b1, 1'b1, R_QUIET},
        '{OP_RSVD_B,     8'h00, 1'b0, 1'b1, R_QUIET},
        '{OP_SEND_BYTE,  8'hFF, 1'b0, 1'b1, R_ARMED},
        '{OP_RECEIVE,    8'h00, 1'b1, 1'b1, R_DROPPED},
        '{OP_RSVD_C,     8'h00, 1'b1, 1'b1, R_ARMED},
        '{OP_SEND_IDLE,  8'h3C, 1'b0, 1'b1, R_DROPPED},
        '{OP_TICK,       8'h00, 1'b0, 1'b0, R_QUIET},
        '{OP_TICK,       8'hFF, 1'b1, 1'b0, R_QUIET},
        '{OP_TICK,       8'h00, 1'b0, 1'b0, R_QUIET},
        '{OP_TICK,       8'hFF, 1'b1, 1'b0, R_QUIET},
        '{OP_TICK,       8'h00, 1'b0, 1'b0, R_QUIET},
        '{OP_TICK,       8'hFF, 1'b1, 1'b0, R_QUIET},
        '{OP_TICK,       8'h00, 1'b0, 1'b0, R_QUIET},
        '{OP_TICK,       8'hFF, 1'b1, 1'b0, R_QUIET},
        '{OP_TICK,       8'h00, 1'b0, 1'b0, R_QUIET},
        '{OP_TICK,       8'hFF, 1'b1, 1'b0, R_QUIET},
        '{OP_TICK,       8'h00, 1'b0, 1'b0, R_QUIET},
        '{OP_TICK,       8'hFF, 1'b1, 1'b0, R_QUIET},
        '{OP_RECEIVE,    8'h00, 1'b1, 1'b1, R_ARMED},
        '{OP_TICK,       8'h00, 1'b1, 1'b0, R_QUIET},
        '{OP_TICK,       8'h00, 1'b0, 1'b0, R_QUIET},
        '{OP_TICK,       8'h00, 1'b1, 1'b0, R_QUIET},
        '{OP_TICK,       8'h00, 1'b1, 1'b0, R_QUIET}
    };

    pdi_frame_phy_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .data_byte   (data_byte),
        .line_in     (line_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_out    (line_out),
        .line_drive  (line_drive),
        .clock_run   (clock_run),
        .busy_res    (busy_res),
        .rx_done     (rx_done),
        .rx_byte     (rx_byte),
        .rx_status   (rx_status),
        .rejected    (rejected)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // advance the engine model by one item and return its result
    function automatic phy_res_t phy_step(input logic [2:0] op, input logic [7:0] db,
                                          input logic li);
        phy_res_t r;
        r = '0;
        r.line_drive = drive_on;
        r.line_out   = drive_on ? frame_bits[11] : 1'b0;
        if (op <= OP_RECEIVE)
        begin
            if (link_phase != PH_IDLE)
            begin
                r.rejected = 1'b1;
            end
            else if (op == OP_RECEIVE)
            begin
                drive_on     = 1'b0;
                link_phase   = PH_RXWAIT;
                wait_left    = timeout_reg;
                rx_acc       = 8'd0;
                rx_err       = ST_OK;
                bit_pos      = 4'd0;
                r.line_drive = 1'b0;
                r.line_out   = 1'b0;
            end
            else
            begin
                // start 0, data lsb first, even parity, two stop 1s
                if (op == OP_SEND_BYTE)
                    frame_bits = 12'hC00 | (12'(db) << 1) | (12'(^db) << 9);
                else if (op == OP_SEND_IDLE)
                    frame_bits = 12'hFFF;
                else
                    frame_bits = 12'h000;
                bit_pos    = 4'd0;
                link_phase = PH_TX;
            end
        end
        else if (op == OP_TICK)
        begin
            case (link_phase)
                PH_TX:
                begin
                    drive_on     = 1'b1;
                    r.line_drive = 1'b1;
                    r.line_out   = (bit_pos < 4'd12) ? frame_bits[bit_pos] : 1'b1;
                    r.clock_run  = 1'b1;
                    if (bit_pos + 4'd1 >= 4'd12)
                        link_phase = PH_IDLE;
                    bit_pos = bit_pos + 4'd1;
                end
                PH_RXWAIT:
                begin
                    if (wait_left == 8'd0)
                    begin
                        r.rx_done   = 1'b1;
                        r.rx_status = ST_TIMEOUT;
                        link_phase  = PH_IDLE;
                    end
                    else
                    begin
                        r.clock_run = 1'b1;
                        wait_left   = wait_left - 8'd1;
                        if (li == 1'b0)
                        begin
                            link_phase = PH_RXDATA;
                            bit_pos    = 4'd0;
                            rx_acc     = 8'd0;
                            rx_err     = ST_OK;
                        end
                        else if (wait_left == 8'd0)
                        begin
                            r.rx_done   = 1'b1;
                            r.rx_status = ST_TIMEOUT;
                            link_phase  = PH_IDLE;
                        end
                    end
                end
                PH_RXDATA:
                begin
                    r.clock_run = 1'b1;
                    if (bit_pos < 4'd8)
                        rx_acc[bit_pos[2:0]] = rx_acc[bit_pos[2:0]] | li;
                    else if (bit_pos == 4'd8)
                    begin
                        if (li != ^rx_acc)
                            rx_err = ST_PARITY;
                    end
                    else if (rx_err == ST_OK && li == 1'b0)
                        rx_err = ST_BADSTOP;
                    if (bit_pos >= 4'd10)
                    begin
                        r.rx_done   = 1'b1;
                        r.rx_byte   = rx_acc;
                        r.rx_status = rx_err;
                        link_phase  = PH_IDLE;
                        bit_pos     = 4'd0;
                    end
                    else
                        bit_pos = bit_pos + 4'd1;
                end
                default:
                begin
                end
            endcase
        end
        r.busy_res = (link_phase != PH_IDLE);
        return r;
    endfunction

    // offer one item, wait for acceptance, then queue its result
    task automatic drive_item(input logic [2:0] op, input logic [7:0] db, input logic li,
                              input bit fixed, input phy_res_t fixed_res);
        phy_res_t r;
        int       gap;
        if (!(op > OP_TICK || (op == OP_TICK && link_phase == PH_IDLE)))
            items_sent++;
        r = phy_step(op, db, li);
        if (fixed)
            r = fixed_res;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= db;
        line_in   <= li;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(r);
    endtask

    task automatic tick(input logic li);
        drive_item(OP_TICK, 8'($urandom), li, 1'b0, R_QUIET);
    endtask

    // tick until the frame in progress is over
    task automatic finish_frame();
        while (link_phase != PH_IDLE)
            tick(1'($urandom_range(0, 1)));
    endtask

    // drop valid and wait until every result item is back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // a send frame, now and then with a stray command between ticks
    task automatic send_frame();
        int         pick;
        logic [2:0] op;
        pick = $urandom_range(0, 5);
        op   = (pick < 4) ? OP_SEND_BYTE : (pick == 4) ? OP_SEND_IDLE : OP_SEND_BREAK;
        drive_item(op, 8'($urandom), 1'($urandom), 1'b0, R_QUIET);
        while (link_phase == PH_TX)
        begin
            if ($urandom_range(0, 15) == 0)
                drive_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'b0, R_QUIET);
            tick(1'($urandom));
        end
    endtask

    // a receive: idle ones, start bit, data, parity and stops, sometimes broken
    task automatic receive_frame();
        int         lead;
        logic [7:0] payload;
        drive_item(OP_RECEIVE, 8'($urandom), 1'($urandom), 1'b0, R_QUIET);
        if (link_phase != PH_RXWAIT)
            return;
        lead = ($urandom_range(0, 7) == 0) ? $urandom_range(0, int'(timeout_reg) + 1)
                                           : $urandom_range(0, 3);
        repeat (lead)
            if (link_phase == PH_RXWAIT)
                tick(1'b1);
        if (link_phase != PH_RXWAIT)
            return;
        tick(1'b0);
        if (link_phase != PH_RXDATA)
            return;
        payload = 8'($urandom);
        for (int i = 0; i < 8; i++)
            tick(payload[i]);
        tick((^payload) ^ ($urandom_range(0, 5) == 0));
        tick($urandom_range(0, 5) != 0);
        tick($urandom_range(0, 5) != 0);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        timeout_reg = value;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result side stalls a random number of cycles before each item
    initial
    begin
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // compare every accepted result with the oldest pending one
    always @(posedge clk)
    begin
        phy_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no command pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("line_out",   want.line_out,   line_out);
                check_field("line_drive", want.line_drive, line_drive);
                check_field("clock_run",  want.clock_run,  clock_run);
                check_field("busy_res",   want.busy_res,   busy_res);
                check_field("rx_done",    want.rx_done,    rx_done);
                check_field("rx_byte",    want.rx_byte,    rx_byte);
                check_field("rx_status",  want.rx_status,  rx_status);
                check_field("rejected",   want.rejected,   rejected);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        int         target;
        int         pick;
        logic [7:0] setting;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 8'd0;
        in_valid     = 1'b0;
        operation    = OP_TICK;
        data_byte    = 8'd0;
        line_in      = 1'b1;
        fail_count   = 0;
        items_sent   = 0;
        stuck_cycles = 0;
        calm         = 1'b0;
        link_phase   = PH_IDLE;
        frame_bits   = 12'hFFF;
        bit_pos      = 4'd0;
        wait_left    = 8'd0;
        rx_acc       = 8'd0;
        rx_err       = ST_OK;
        drive_on     = 1'b0;
        timeout_reg  = TIMEOUT_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_tab[i])
            drive_item(dir_tab[i].op, dir_tab[i].db, dir_tab[i].li, dir_tab[i].fixed,
                       dir_tab[i].res);
        finish_frame();
        settle();

        // random frames under several timeout settings
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                case (p)
                    1: setting = 8'd1;
                    2: setting = 8'd255;
                    3: setting = 8'd0;
                    default: setting = 8'($urandom_range(1, 24));
                endcase
                write_timeout(setting);
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    send_frame();
                else if (pick < 8)
                    receive_frame();
                else
                    repeat ($urandom_range(1, 4))
                        drive_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                                   1'b0, R_QUIET);
            end
            calm = 1'b0;
            finish_frame();
            settle();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
